// File: design/lzd_pkg.sv
// shared types and constants of the lz77 byte token decoder
package lzd_pkg;

  localparam int DEF_MAX_WINDOW = 4096;
  localparam int CFG_W          = 13;
  localparam int CFG_RST        = 4096;
  localparam int MIN_WINDOW     = 2;
  localparam int LEN_W          = 24;
  localparam int DIST_W         = 16;
  localparam int IN_W           = 8;
  localparam int OUT_W          = 16;

  localparam logic [LEN_W-1:0]  LEN_MAX  = {LEN_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [7:0]        ESC_BYTE = 8'hFF;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    PH_LENGTH,
    PH_DISTANCE,
    PH_LITERAL
  } phase_t;

  // per request control bundle from the token parser to the write/output stage
  typedef struct packed {
    logic       wr;
    logic       copy;
    logic       refused;
    logic       derr;
    logic       busy;
    logic [7:0] lit;
  } lzd_step_t;

endpackage

// File: design/lz77_byte_token_decoder.sv
// top level of the lz77 byte token decoder
// Decodes a byte-aligned lz77 token stream (length, optional distance, literal) into a ring
// window held in one synchronous ram. Each request on the slave side gives exactly one
// response on the master side, in order. One request is taken per clock in steady flow;
// a request's response passes the ram read stage, then the output register, and the
// window write of a byte lands together with its response. After reset the window ram
// is cleared one byte per cycle, so no request is taken until the whole ram is swept.
// After a write of window_size the write cursor and copy source are folded into the new
// size by a restoring reducer, one bit per cycle, which holds off requests while it runs.
// Configuration writes are always taken.
module lz77_byte_token_decoder
  import lzd_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic             clk,
  input  logic             rst,
  // window_size register write
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  // slave side: tdata = in_byte[7:0]; tuser = req_type
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             s_tuser,
  // master side: tdata = out_byte[7:0], refused[8], dist_error[9], busy_res[10], zero[15:11]
  // tuser = out_valid
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tuser
);

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int WSW  = AW + 1;
  localparam int EXW  = (WSW > CFG_W) ? WSW : CFG_W;
  localparam int WS_RST = (CFG_RST > MAX_WINDOW) ? MAX_WINDOW : CFG_RST;

  // effective window size, clamped at write time
  logic [WSW-1:0] ws;
  logic [EXW-1:0] cfg_ext;
  logic [EXW-1:0] ws_clamp;

  // window clear sweep after reset
  logic           clearing;
  logic [AW-1:0]  clr_cnt;

  // reducer hookup
  logic           red_busy;
  logic           red_done;
  logic [AW-1:0]  red_cur;
  logic [AW-1:0]  red_src;
  logic [AW-1:0]  cur_raw;
  logic [AW-1:0]  src_raw;

  // parser outputs
  logic           accept;
  lzd_step_t      step;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;

  // ram stage: holds a request while its read data comes back
  logic           s1_valid;
  lzd_step_t      s1_step;
  logic [AW-1:0]  s1_addr;
  logic           s1_fwd_hit;
  logic [7:0]     s1_fwd_data;
  logic           s1_adv;
  logic [7:0]     s1_byte;
  logic [7:0]     ram_q;

  // ram port mux
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;

  assign cfg_ext = EXW'(cfg_wdata);

  always_comb begin
    if (cfg_ext < EXW'(MIN_WINDOW)) begin
      ws_clamp = EXW'(MIN_WINDOW);
    end else if (cfg_ext > EXW'(MAX_WINDOW)) begin
      ws_clamp = EXW'(MAX_WINDOW);
    end else begin
      ws_clamp = cfg_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ws <= WSW'(WS_RST);
    end else if (cfg_we) begin
      ws <= WSW'(ws_clamp);
    end
  end

  // zero one window byte per cycle until the whole ram is swept
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(MAX_WINDOW - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // a request moves into the ram stage when that stage is empty or drains this cycle
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clearing && !red_busy && !red_done && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  lzd_wrap_reduce #(
    .AW (AW)
  ) u_reduce (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_we),
    .ws      (ws),
    .cur_in  (cur_raw),
    .src_in  (src_raw),
    .busy    (red_busy),
    .done    (red_done),
    .cur_out (red_cur),
    .src_out (red_src)
  );

  lzd_token_ctrl #(
    .AW (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (s_tuser),
    .in_byte  (s_tdata),
    .ws       (ws),
    .red_done (red_done),
    .red_cur  (red_cur),
    .red_src  (red_src),
    .cur_raw  (cur_raw),
    .src_raw  (src_raw),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .step     (step)
  );

  // copy byte comes from the ram, or from the byte being written as it is read
  always_comb begin
    if (!s1_step.wr) begin
      s1_byte = 8'h00;
    end else if (!s1_step.copy) begin
      s1_byte = s1_step.lit;
    end else if (s1_fwd_hit) begin
      s1_byte = s1_fwd_data;
    end else begin
      s1_byte = ram_q;
    end
  end

  assign ram_we    = clearing || (s1_adv && s1_step.wr);
  assign ram_waddr = clearing ? clr_cnt : s1_addr;
  assign ram_wdata = clearing ? 8'h00 : s1_byte;

  lzd_window_ram #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // the ram returns old data on a same-cycle write, so catch that write here
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step     <= step;
      s1_addr     <= wr_addr;
      s1_fwd_hit  <= s1_adv && s1_step.wr && (s1_addr == rd_addr);
      s1_fwd_data <= s1_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tuser <= s1_step.wr;
      m_tdata <= {(OUT_W - 11)'(0), s1_step.busy, s1_step.derr, s1_step.refused, s1_byte};
    end
  end

endmodule

// File: design/lzd_window_ram.sv
// ring window memory, one write port and one registered read port
module lzd_window_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // old data on a read of the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/lzd_wrap_reduce.sv
// restoring reduction of cursor and copy source modulo a new window size
module lzd_wrap_reduce #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW:0]   ws,
  input  logic [AW-1:0] cur_in,
  input  logic [AW-1:0] src_in,
  output logic          busy,
  output logic          done,
  output logic [AW-1:0] cur_out,
  output logic [AW-1:0] src_out
);

  localparam int KW   = (AW > 1) ? $clog2(AW) : 1;
  localparam int WIDE = 2 * AW + 1;

  logic [KW-1:0]   k;
  logic [WIDE-1:0] div;
  logic            cur_ge;
  logic            src_ge;

  assign div    = WIDE'(ws) << k;
  assign cur_ge = WIDE'(cur_out) >= div;
  assign src_ge = WIDE'(src_out) >= div;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      k    <= KW'(AW - 1);
    end else if (busy) begin
      k <= k - 1'b1;
      if (k == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur_out <= cur_in;
      src_out <= src_in;
    end else if (busy) begin
      if (cur_ge) begin
        cur_out <= cur_out - div[AW-1:0];
      end
      if (src_ge) begin
        src_out <= src_out - div[AW-1:0];
      end
    end
  end

endmodule

// File: design/lzd_token_ctrl.sv
// token parser: length and distance accumulation, cursor and copy bookkeeping
module lzd_token_ctrl
  import lzd_pkg::*;
#(
  parameter int AW = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            req_type,
  input  logic [7:0]      in_byte,
  input  logic [AW:0]     ws,
  input  logic            red_done,
  input  logic [AW-1:0]   red_cur,
  input  logic [AW-1:0]   red_src,
  output logic [AW-1:0]   cur_raw,
  output logic [AW-1:0]   src_raw,
  output logic [AW-1:0]   rd_addr,
  output logic [AW-1:0]   wr_addr,
  output lzd_step_t       step
);

  localparam int CMPW = (DIST_W > AW + 1) ? DIST_W : AW + 1;
  localparam int SW   = AW + 2;

  phase_t             phase;
  phase_t             phase_next;
  logic [AW-1:0]      cur;
  logic [AW-1:0]      src;
  logic [AW-1:0]      cur_next;
  logic [AW-1:0]      src_next;
  logic [LEN_W-1:0]   rem;
  logic [LEN_W-1:0]   rem_next;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_next;
  logic [DIST_W-1:0]  dist_acc;
  logic [DIST_W-1:0]  dist_acc_next;

  logic [LEN_W:0]     len_sum;
  logic [LEN_W-1:0]   len_sat;
  logic [DIST_W:0]    dist_sum;
  logic [DIST_W-1:0]  dist_sat;
  logic               esc;
  logic               dist_big;
  logic [AW-1:0]      cur_inc;
  logic [AW-1:0]      src_inc;
  logic [SW-1:0]      back_sum;
  logic [AW-1:0]      back_src;
  logic               parse;
  logic               src_set;

  assign len_sum  = {1'b0, len} + (LEN_W + 1)'(in_byte);
  assign len_sat  = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
  assign dist_sum = {1'b0, dist_acc} + (DIST_W + 1)'(in_byte);
  assign dist_sat = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
  assign esc      = in_byte == ESC_BYTE;
  assign dist_big = CMPW'(dist_sat) >= CMPW'(ws);

  // both pointers are kept below the window size, so a wrap is an equality test
  assign cur_inc = ({1'b0, cur} + 1'b1 == ws) ? '0 : cur + 1'b1;
  assign src_inc = ({1'b0, src} + 1'b1 == ws) ? '0 : src + 1'b1;

  // start of copy: cursor - 1 - distance, folded into the ring
  assign back_sum = SW'(cur) + SW'(ws) - SW'(1) - SW'(dist_sat);
  assign back_src = (back_sum >= SW'(ws)) ? AW'(back_sum - SW'(ws)) : back_sum[AW-1:0];

  assign parse   = accept && (req_type == REQ_BYTE) && (rem == '0);
  assign rd_addr = src;
  assign wr_addr = cur;

  always_comb begin
    phase_next = phase;
    if (parse) begin
      case (phase)
        PH_LENGTH: begin
          if (!esc) begin
            phase_next = (len_sat != '0) ? PH_DISTANCE : PH_LITERAL;
          end
        end
        PH_DISTANCE: begin
          if (!esc) begin
            phase_next = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          phase_next = PH_LENGTH;
        end
        default: begin
          phase_next = PH_LENGTH;
        end
      endcase
    end
  end

  always_comb begin
    cur_next      = cur;
    src_next      = src;
    rem_next      = rem;
    len_next      = len;
    dist_acc_next = dist_acc;
    src_set       = 1'b0;
    step          = '0;
    if (accept) begin
      if (req_type == REQ_DRAIN) begin
        if (rem != '0) begin
          step.wr   = 1'b1;
          step.copy = 1'b1;
          cur_next  = cur_inc;
          src_next  = src_inc;
          src_set   = 1'b1;
          rem_next  = rem - 1'b1;
        end
      end else if (rem != '0) begin
        step.refused = 1'b1;
      end else begin
        case (phase)
          PH_LENGTH: begin
            len_next = len_sat;
            if (!esc) begin
              dist_acc_next = '0;
            end
          end
          PH_DISTANCE: begin
            dist_acc_next = dist_sat;
            if (!esc) begin
              if (dist_big) begin
                step.derr = 1'b1;
              end else begin
                src_next = back_src;
                src_set  = 1'b1;
                rem_next = len;
              end
              len_next      = '0;
              dist_acc_next = '0;
            end
          end
          default: begin
            step.wr       = 1'b1;
            step.lit      = in_byte;
            cur_next      = cur_inc;
            len_next      = '0;
            dist_acc_next = '0;
          end
        endcase
      end
      step.busy = rem_next != '0;
    end
  end

  // cur_raw and src_raw keep the values last set by a request, unfolded by later
  // size changes, so each new size folds the value the stream actually left
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LENGTH;
      cur      <= '0;
      src      <= '0;
      cur_raw  <= '0;
      src_raw  <= '0;
      rem      <= '0;
      len      <= '0;
      dist_acc <= '0;
    end else begin
      phase    <= phase_next;
      rem      <= rem_next;
      len      <= len_next;
      dist_acc <= dist_acc_next;
      if (step.wr) begin
        cur_raw <= cur_next;
      end
      if (src_set) begin
        src_raw <= src_next;
      end
      if (red_done) begin
        cur <= red_cur;
        src <= red_src;
      end else begin
        cur <= cur_next;
        src <= src_next;
      end
    end
  end

endmodule
